// ===== rtl/optt_pkg.sv =====
// Package for the oscillation peak/trough tracker.
// Holds field widths, beat types, queue entry type and sample class codes.
// No dependencies.
`default_nettype none

package optt_pkg;

  localparam int SampleWidth = 24;
  localparam int TimeWidth   = 32;
  localparam int CountWidth  = 16;
  localparam int QueueDepth  = 2;
  localparam int QueuePtrW   = $clog2(QueueDepth);
  localparam int QueueCntW   = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    ClsEqual = 2'd0,
    ClsBelow = 2'd1,
    ClsAbove = 2'd2
  } sample_cls_e;

  typedef struct packed {
    logic        [TimeWidth-1:0]   sample_time;
    logic signed [SampleWidth-1:0] displacement;
    logic                          end_of_data;
  } in_beat_t;

  typedef struct packed {
    logic        [CountWidth-1:0]  cycle_index;
    logic        [TimeWidth-1:0]   trough_time;
    logic signed [SampleWidth-1:0] trough_value;
    logic        [TimeWidth-1:0]   peak_time;
    logic signed [SampleWidth-1:0] peak_value;
    logic                          peak_found;
    logic                          last_of_run;
  } out_beat_t;

  typedef struct packed {
    in_beat_t    beat;
    sample_cls_e cls;
  } queue_entry_t;

endpackage

`default_nettype wire

// ===== rtl/optt_front.sv =====
// Front end: holds the mid level register and classifies each input beat
// against it before it enters the queue. Depends on optt_pkg.
`default_nettype none

module optt_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic signed [optt_pkg::SampleWidth-1:0] cfg_data_i,
  input  wire optt_pkg::in_beat_t                in_data_i,
  output optt_pkg::queue_entry_t                 entry_o
);

  logic signed [optt_pkg::SampleWidth-1:0] mid_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_level_q <= '0;
    end else if (cfg_valid_i) begin
      mid_level_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    entry_o.beat = in_data_i;
    if ($signed(in_data_i.displacement) < $signed(mid_level_q)) begin
      entry_o.cls = optt_pkg::ClsBelow;
    end else if ($signed(in_data_i.displacement) > $signed(mid_level_q)) begin
      entry_o.cls = optt_pkg::ClsAbove;
    end else begin
      entry_o.cls = optt_pkg::ClsEqual;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/optt_queue.sv =====
// Short FIFO between the classifier and the tracking back end.
// Depends on optt_pkg for depth and entry type.
`default_nettype none

module optt_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_valid_i,
  output logic                        push_ready_o,
  input  wire optt_pkg::queue_entry_t push_data_i,
  output logic                        pop_valid_o,
  input  wire logic                   pop_ready_i,
  output optt_pkg::queue_entry_t      pop_data_o
);

  optt_pkg::queue_entry_t mem_q [optt_pkg::QueueDepth];
  logic [optt_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [optt_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [optt_pkg::QueueCntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != optt_pkg::QueueCntW'(optt_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == optt_pkg::QueuePtrW'(optt_pkg::QueueDepth - 1))
                 ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == optt_pkg::QueuePtrW'(optt_pkg::QueueDepth - 1))
                 ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/optt_back.sv =====
// Back end: per-cycle trough/peak tracking state, record building and the
// output register with a one-entry hold for a second record. Depends on optt_pkg.
`default_nettype none

module optt_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   q_valid_i,
  output logic                        q_ready_o,
  input  wire optt_pkg::queue_entry_t q_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output optt_pkg::out_beat_t         out_data_o
);

  logic                                    started_q, started_d;
  logic                                    above_q, above_d;
  logic                                    pk_seen_q, pk_seen_d;
  logic        [optt_pkg::CountWidth-1:0]  cnt_q, cnt_d;
  logic        [optt_pkg::TimeWidth-1:0]   tr_t_q, tr_t_d, pk_t_q, pk_t_d;
  logic signed [optt_pkg::SampleWidth-1:0] tr_v_q, tr_v_d, pk_v_q, pk_v_d;

  logic                out_valid_q, out_valid_d;
  optt_pkg::out_beat_t out_q, out_d;
  logic                pend_valid_q, pend_valid_d;
  optt_pkg::out_beat_t pend_q, pend_d;

  logic                slot_free, pop, close, eod;
  optt_pkg::out_beat_t rec_close, rec_eod;
  logic        [optt_pkg::TimeWidth-1:0]   t;
  logic signed [optt_pkg::SampleWidth-1:0] d;

  function automatic optt_pkg::out_beat_t make_rec(
    input logic        [optt_pkg::CountWidth-1:0]  cnt,
    input logic        [optt_pkg::TimeWidth-1:0]   tt,
    input logic signed [optt_pkg::SampleWidth-1:0] tv,
    input logic        [optt_pkg::TimeWidth-1:0]   pt,
    input logic signed [optt_pkg::SampleWidth-1:0] pv,
    input logic                                    seen,
    input logic                                    last
  );
    optt_pkg::out_beat_t r;
    r.cycle_index  = cnt;
    r.trough_time  = tt;
    r.trough_value = tv;
    r.peak_time    = seen ? pt : '0;
    r.peak_value   = seen ? pv : '0;
    r.peak_found   = seen;
    r.last_of_run  = last;
    return r;
  endfunction

  assign t   = q_data_i.beat.sample_time;
  assign d   = q_data_i.beat.displacement;
  assign eod = q_data_i.beat.end_of_data;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign q_ready_o   = slot_free && !pend_valid_q;
  assign pop         = q_valid_i && q_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // tracking update
  always_comb begin
    started_d = started_q;
    above_d   = above_q;
    pk_seen_d = pk_seen_q;
    cnt_d     = cnt_q;
    tr_t_d    = tr_t_q;
    tr_v_d    = tr_v_q;
    pk_t_d    = pk_t_q;
    pk_v_d    = pk_v_q;
    close     = 1'b0;
    if (!started_q) begin
      started_d = 1'b1;
      tr_t_d    = t;
      tr_v_d    = d;
    end else begin
      unique case (q_data_i.cls)
        optt_pkg::ClsBelow: begin
          if (above_q) begin
            close     = 1'b1;
            cnt_d     = cnt_q + 1'b1;
            above_d   = 1'b0;
            pk_seen_d = 1'b0;
            pk_t_d    = '0;
            pk_v_d    = '0;
            tr_t_d    = t;
            tr_v_d    = d;
          end else if ($signed(d) < $signed(tr_v_q)) begin
            tr_t_d = t;
            tr_v_d = d;
          end
        end
        optt_pkg::ClsAbove: begin
          if (!above_q) begin
            above_d   = 1'b1;
            pk_seen_d = 1'b1;
            pk_t_d    = t;
            pk_v_d    = d;
          end else if ($signed(d) > $signed(pk_v_q)) begin
            pk_t_d = t;
            pk_v_d = d;
          end
        end
        default: begin
        end
      endcase
    end
    rec_close = make_rec(cnt_q, tr_t_q, tr_v_q, pk_t_q, pk_v_q, pk_seen_q, !eod);
    rec_eod   = make_rec(cnt_d, tr_t_d, tr_v_d, pk_t_d, pk_v_d, pk_seen_d, 1'b1);
  end

  // output register and held second record
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (slot_free) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = pend_q;
        pend_valid_d = 1'b0;
      end else if (pop) begin
        if (close) begin
          out_valid_d = 1'b1;
          out_d       = rec_close;
          if (eod) begin
            pend_valid_d = 1'b1;
            pend_d       = rec_eod;
          end
        end else if (eod) begin
          out_valid_d = 1'b1;
          out_d       = rec_eod;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q    <= 1'b0;
      above_q      <= 1'b0;
      pk_seen_q    <= 1'b0;
      cnt_q        <= '0;
      tr_t_q       <= '0;
      tr_v_q       <= '0;
      pk_t_q       <= '0;
      pk_v_q       <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      if (pop) begin
        if (eod) begin
          started_q <= 1'b0;
          above_q   <= 1'b0;
          pk_seen_q <= 1'b0;
          cnt_q     <= '0;
          tr_t_q    <= '0;
          tr_v_q    <= '0;
          pk_t_q    <= '0;
          pk_v_q    <= '0;
        end else begin
          started_q <= started_d;
          above_q   <= above_d;
          pk_seen_q <= pk_seen_d;
          cnt_q     <= cnt_d;
          tr_t_q    <= tr_t_d;
          tr_v_q    <= tr_v_d;
          pk_t_q    <= pk_t_d;
          pk_v_q    <= pk_v_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

endmodule

`default_nettype wire

// ===== rtl/oscillation_peak_trough_tracker.sv =====
// Oscillation peak/trough tracker, top level: classifier, queue, tracking back end.
// The beat that closes a record is written into the queue; the back end then pops
// it and registers the record. Throughput: one input beat per cycle while the queue
// is not full; a beat that both closes a cycle and ends the record yields two output
// beats, the second held in the back end, which pops nothing while it is held.
// Reset clears all tracking state, the queue and mid_level.
// Depends on optt_pkg, optt_front, optt_queue, optt_back.
`default_nettype none

module oscillation_peak_trough_tracker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic signed [optt_pkg::SampleWidth-1:0] cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire optt_pkg::in_beat_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output optt_pkg::out_beat_t                    out_data_o
);

  optt_pkg::queue_entry_t entry, q_data;
  logic                   q_valid, q_ready;

  optt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .entry_o     (entry)
  );

  optt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (entry),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  optt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_oscillation_peak_trough_tracker.sv =====
// Self-checking testbench for oscillation_peak_trough_tracker: drives sample beats and mid_level
// writes, predicts each cycle record in SV and checks every output beat field by field.
// Depends on optt_pkg and the oscillation_peak_trough_tracker RTL.
`default_nettype none

module tb_oscillation_peak_trough_tracker;
  import optt_pkg::*;

  localparam int SampleMax = 2 ** (SampleWidth - 1) - 1;
  localparam int SampleMin = -(2 ** (SampleWidth - 1));

  typedef enum int {
    ReadyAlways,
    ReadyCoin,
    ReadyEvery,
    ReadyRare
  } ready_mode_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic signed [SampleWidth-1:0] cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  in_beat_t                      in_data_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  out_beat_t                     out_data_o;

  oscillation_peak_trough_tracker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // predictor state
  logic signed [SampleWidth-1:0] mid_q;
  logic                          tracking;
  logic                          in_peak_phase;
  logic                          peak_hit;
  logic [CountWidth-1:0]         cycle_no;
  logic [TimeWidth-1:0]          low_time;
  logic signed [SampleWidth-1:0] low_val;
  logic [TimeWidth-1:0]          high_time;
  logic signed [SampleWidth-1:0] high_val;
  out_beat_t                     expected_records[$];

  int          err_count = 0;
  int          burst_left = 0;
  int          gap_max = 6;
  logic        quiet = 1'b0;
  ready_mode_e ready_mode = ReadyAlways;
  int          pattern_left = 0;
  int          pattern_step = 2;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic clear_tracking();
    tracking      = 1'b0;
    in_peak_phase = 1'b0;
    peak_hit      = 1'b0;
    cycle_no      = '0;
    low_time      = '0;
    low_val       = '0;
    high_time     = '0;
    high_val      = '0;
  endtask

  function automatic out_beat_t cycle_record(input logic last);
    out_beat_t r;
    r.cycle_index  = cycle_no;
    r.trough_time  = low_time;
    r.trough_value = low_val;
    r.peak_time    = peak_hit ? high_time : '0;
    r.peak_value   = peak_hit ? high_val : '0;
    r.peak_found   = peak_hit;
    r.last_of_run  = last;
    return r;
  endfunction

  task automatic track_sample(input in_beat_t b);
    logic signed [SampleWidth-1:0] d;
    d = b.displacement;
    if (!tracking) begin
      tracking = 1'b1;
      low_time = b.sample_time;
      low_val  = d;
    end else if (d < mid_q) begin
      if (in_peak_phase) begin
        expected_records.push_back(cycle_record(!b.end_of_data));
        cycle_no      = cycle_no + 1'b1;
        in_peak_phase = 1'b0;
        peak_hit      = 1'b0;
        high_time     = '0;
        high_val      = '0;
        low_time      = b.sample_time;
        low_val       = d;
      end else if (d < low_val) begin
        low_time = b.sample_time;
        low_val  = d;
      end
    end else if (d > mid_q) begin
      if (!in_peak_phase) begin
        in_peak_phase = 1'b1;
        peak_hit      = 1'b1;
        high_time     = b.sample_time;
        high_val      = d;
      end else if (d > high_val) begin
        high_time = b.sample_time;
        high_val  = d;
      end
    end
    if (b.end_of_data) begin
      expected_records.push_back(cycle_record(1'b1));
      clear_tracking();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %h actual %h", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic check_record(input out_beat_t got);
    out_beat_t want;
    if (expected_records.size() == 0) begin
      $display("%0t unexpected record: expected none actual %h", $time, got);
      err_count++;
    end else begin
      want = expected_records.pop_front();
      check_field("cycle_index", 32'(want.cycle_index), 32'(got.cycle_index));
      check_field("trough_time", want.trough_time, got.trough_time);
      check_field("trough_value", 32'(want.trough_value), 32'(got.trough_value));
      check_field("peak_time", want.peak_time, got.peak_time);
      check_field("peak_value", 32'(want.peak_value), 32'(got.peak_value));
      check_field("peak_found", 32'(want.peak_found), 32'(got.peak_found));
      check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_record(out_data_o);
  end

  // output back-pressure, independent of the sender
  always @(negedge clk_i) begin
    if (pattern_left == 0) begin
      ready_mode   = ready_mode_e'($urandom_range(0, 3));
      pattern_left = $urandom_range(8, 64);
      pattern_step = $urandom_range(2, 4);
    end
    pattern_left--;
    if (quiet) begin
      out_ready_i <= ($urandom_range(0, 15) != 0);
    end else begin
      case (ready_mode)
        ReadyAlways: out_ready_i <= 1'b1;
        ReadyCoin:   out_ready_i <= 1'($urandom_range(0, 1));
        ReadyEvery:  out_ready_i <= (pattern_left % pattern_step == 0);
        default:     out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // called and returns at a falling edge; valid stays high into the next beat
  task automatic send_sample(input logic [TimeWidth-1:0] t,
                             input logic signed [SampleWidth-1:0] d, input logic eod);
    in_beat_t b;
    int gap;
    b.sample_time  = t;
    b.displacement = d;
    b.end_of_data  = eod;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    track_sample(b);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_records.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_mid_level(input logic signed [SampleWidth-1:0] v);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    mid_q = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // value strictly above or below mid level, spread over many magnitudes (mid level itself if that side has no room)
  function automatic logic signed [SampleWidth-1:0] pick_level(input logic want_above);
    int m;
    int room;
    int off;
    m    = mid_q;
    room = want_above ? (SampleMax - m) : (m - SampleMin);
    if (room == 0) return mid_q;
    off = $urandom_range(1, 1 << $urandom_range(0, SampleWidth - 1));
    if (off > room) off = 1 + (off % room);
    return SampleWidth'(want_above ? m + off : m - off);
  endfunction

  task automatic test_directed();
    // mid level at its reset value of zero
    send_sample(32'd0, 5, 1'b0);               // first sample above mid seeds the trough
    send_sample(32'd1, 0, 1'b0);               // equal to mid, ignored
    send_sample(32'd2, -3, 1'b0);
    send_sample(32'd3, SampleMin, 1'b0);
    send_sample(32'd4, -2, 1'b0);
    send_sample(32'd5, 7, 1'b0);               // new peak phase
    send_sample(32'd6, 0, 1'b0);
    send_sample(32'd7, SampleMax, 1'b0);
    send_sample(32'd8, 3, 1'b0);
    send_sample(32'd9, -1, 1'b0);              // closes cycle 0
    send_sample(32'd10, -5, 1'b0);
    send_sample(32'd11, 0, 1'b1);              // end of data, no peak phase
    send_sample(32'hffff_ffff, 0, 1'b1);       // single-sample record
    send_sample(32'd20, -4, 1'b0);
    send_sample(32'd21, 4, 1'b0);
    send_sample(32'd22, -6, 1'b1);             // close plus end: two beats
    send_sample(32'hffff_fffe, SampleMax, 1'b0);
    send_sample(32'd0, SampleMin, 1'b0);
    send_sample(32'd1, 1, 1'b1);
  endtask

  task automatic test_mid_extremes();
    write_mid_level(SampleMin);
    send_sample(32'd100, SampleMin, 1'b0);
    send_sample(32'd101, SampleMin, 1'b0);
    send_sample(32'd102, 100, 1'b0);
    send_sample(32'd103, SampleMax, 1'b0);
    send_sample(32'd104, -1, 1'b1);
    write_mid_level(SampleMax);
    send_sample(32'd200, SampleMax, 1'b0);
    send_sample(32'd201, SampleMin, 1'b0);
    send_sample(32'd202, SampleMax, 1'b0);
    send_sample(32'd203, 0, 1'b1);
  endtask

  task automatic send_wave(input int n);
    logic                          above;
    logic [TimeWidth-1:0]          t;
    logic signed [SampleWidth-1:0] d;
    logic                          eod;
    int                            run;
    int                            pick;
    int                            rec_left;
    int                            sent;
    above    = 1'($urandom_range(0, 1));
    run      = 0;
    t        = $urandom();
    rec_left = $urandom_range(4, 60);
    for (sent = 0; sent < n; sent++) begin
      if (run == 0) begin
        above = !above;
        run   = $urandom_range(1, 5);
      end
      run--;
      pick = $urandom_range(0, 99);
      if (pick < 8) d = mid_q;
      else if (pick < 20) d = SampleWidth'($urandom());
      else d = pick_level(above);
      if ($urandom_range(0, 19) == 0) t = $urandom();
      else t = t + $urandom_range(1, 1000);
      rec_left--;
      eod = (rec_left <= 0) || ($urandom_range(0, 49) == 0);
      if (eod) rec_left = $urandom_range(1, 60);
      send_sample(t, d, eod);
    end
  endtask

  task automatic test_random_oscillation();
    int k;
    for (k = 0; k < 6; k++) begin
      case (k)
        0: write_mid_level(0);
        1: write_mid_level(SampleMin);
        2: write_mid_level(SampleMax);
        3: write_mid_level(SampleWidth'($urandom_range(0, 2000) - 1000));
        default: write_mid_level(SampleWidth'($urandom()));
      endcase
      send_wave(230);
    end
  endtask

  task automatic test_back_to_back();
    logic [TimeWidth-1:0] t;
    int                   i;
    write_mid_level(0);
    quiet   = 1'b1;
    gap_max = 0;
    t       = $urandom();
    for (i = 0; i < 20; i++) begin
      send_sample(t, pick_level(1'b0), 1'b0);
      t = t + 1'b1;
      send_sample(t, pick_level(1'b1), 1'b0);
      t = t + 1'b1;
    end
    send_sample(t, pick_level(1'b0), 1'b1);
    quiet   = 1'b0;
    gap_max = 6;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    mid_q       = '0;
    clear_tracking();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_mid_extremes();
    test_random_oscillation();
    test_back_to_back();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== oscillation_peak_trough_tracker.f =====
rtl/optt_pkg.sv
rtl/optt_front.sv
rtl/optt_queue.sv
rtl/optt_back.sv
rtl/oscillation_peak_trough_tracker.sv
tb/tb_oscillation_peak_trough_tracker.sv
